// File: hdl/shell_line_editor_top_macros.svh
// Assertion macros for the shell line editor.
// Used by shell_line_editor_top; needs no other file.
`ifndef SHELL_LINE_EDITOR_TOP_MACROS_SVH
`define SHELL_LINE_EDITOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, quiet while reset is high.
`define SLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("shell line editor check failed");
// Check a property on every rising clock edge, reset included.
`define SLE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("shell line editor check failed");
`else
`define SLE_ASSERT(label, clk, rst, prop)
`define SLE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: hdl/sle_pkg.sv
// Shared types and constants of the shell line editor.
// Used by sle_decode, shell_line_editor_top, sle_checker and tb_top; depends on nothing.
package sle_pkg;

   localparam int SLE_LINE_DEPTH = 128;
   localparam int SLE_TAB_SPACES = 4;
   // results per item never exceed four (a tab at the default TAB_SPACES)
   localparam int SLE_CNT_W      = 4;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef enum logic [4:0] {
      OP_NONE = 5'b00001,
      OP_CHAR = 5'b00010,
      OP_DEL  = 5'b00100,
      OP_TAB  = 5'b01000,
      OP_EOL  = 5'b10000
   } sle_op_type;

   typedef struct packed {
      sle_op_type           op;
      logic [SLE_CNT_W-1:0] count;
   } sle_dec_type;

endpackage

// File: hdl/sle_decode.sv
// Byte classifier of the shell line editor: picks the operation and result count.
// Depends on sle_pkg.
module sle_decode
   import sle_pkg::*;
#(
   parameter int LINE_DEPTH = SLE_LINE_DEPTH,
   parameter int TAB_SPACES = SLE_TAB_SPACES,
   localparam int FILL_W    = $clog2(LINE_DEPTH + 1)
) (
   input  logic [7:0]        rx_byte,
   input  logic              program_running,
   input  logic [FILL_W-1:0] fill_count,
   output sle_dec_type       dec
);

   localparam logic [FILL_W:0] DEPTH_X = (FILL_W + 1)'(LINE_DEPTH);
   localparam logic [FILL_W:0] TAB_X   = (FILL_W + 1)'(TAB_SPACES);

   logic [FILL_W:0] fill_x;
   logic            allowed;

   assign fill_x  = {1'b0, fill_count};
   assign allowed = rx_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                    8'h5F, 8'h2D, 8'h2E, CH_SPACE};

   always_comb begin
      dec.op    = OP_NONE;
      dec.count = '0;
      if (!program_running) begin
         if (allowed) begin
            if (fill_x < DEPTH_X) begin
               dec.op    = OP_CHAR;
               dec.count = SLE_CNT_W'(1);
            end
         end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
            if (fill_count != '0) begin
               dec.op    = OP_DEL;
               dec.count = SLE_CNT_W'(3);
            end
         end else if (rx_byte == CH_TAB) begin
            // all spaces or none
            if (fill_x + TAB_X <= DEPTH_X) begin
               dec.op    = OP_TAB;
               dec.count = SLE_CNT_W'(TAB_SPACES);
            end
         end else if (rx_byte == CH_LF || rx_byte == CH_CR) begin
            dec.op    = OP_EOL;
            dec.count = SLE_CNT_W'(1);
         end
      end
   end

endmodule

// File: hdl/shell_line_editor_top.sv
// Top level of the shell line editor: fill counter, line memory and result sequencer.
// Depends on sle_pkg, sle_decode and shell_line_editor_top_macros.svh.
//
// Use: terminal bytes arrive on the req_ channel (valid/ready, req_rx_byte).
// Each item yields zero to four result items on the rsp_ channel: the echo of
// a stored character, backspace-space-backspace for a delete, TAB_SPACES
// spaces for a tab, or one line-done item carrying the line length for CR/LF.
// rsp_last_result marks the final result of each input item.
// csr_wr_en with csr_wr_data writes program_running; while set, every byte is
// taken and dropped. Write it only while the block is idle.
// Path: an accepted item is loaded into the sequencer registers; each result
// is then registered in the output register before it shows on rsp_valid.
// Throughput: the sequencer emits one result a cycle while the output register
// is free, writing one line memory entry a cycle for a stored character or tab
// space: one result for a character or end of line, 3 for a delete, TAB_SPACES for a tab.
// Stall: the output register holds its item while rsp_ready is low; the
// sequencer then waits, and req_ready stays low until the current item's
// last result moves into the output register. A new item is taken in that
// same cycle, so req_ready follows rsp_ready while the last result waits.
// Reset (synchronous, active high) clears the fill count, the sequencer,
// the output valid and program_running. The line memory is not cleared.
module shell_line_editor_top
   import sle_pkg::*;
#(
   parameter int LINE_DEPTH = SLE_LINE_DEPTH,
   parameter int TAB_SPACES = SLE_TAB_SPACES
) (
   input  logic       clock,
   input  logic       reset,
   // input item channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   // result item channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_line_done,
   output logic [7:0] rsp_line_length,
   output logic       rsp_last_result,
   // configuration
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

`include "shell_line_editor_top_macros.svh"

   localparam int FILL_W = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);

   // control state
   logic                 program_running_ff, program_running_in;
   logic [FILL_W-1:0]    fill_count_ff, fill_count_in;
   sle_op_type           seq_op_ff, seq_op_in;
   logic [SLE_CNT_W-1:0] seq_cnt_ff, seq_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload of the item in the sequencer
   logic [7:0]           seq_char_ff, seq_char_in;
   logic [FILL_W-1:0]    seq_len_ff, seq_len_in;
   logic [FILL_W-1:0]    wr_ptr_ff, wr_ptr_in;

   // output register payload
   logic                 rsp_echo_valid_ff, rsp_echo_valid_in;
   logic [7:0]           rsp_echo_byte_ff, rsp_echo_byte_in;
   logic                 rsp_line_done_ff, rsp_line_done_in;
   logic [7:0]           rsp_line_length_ff, rsp_line_length_in;
   logic                 rsp_last_result_ff, rsp_last_result_in;

   // line memory, written only
   logic [7:0]           line_mem [LINE_DEPTH];
   logic                 mem_we;
   logic [7:0]           mem_wdata;

   sle_dec_type          dec;
   logic                 accept;
   logic                 emit;
   logic [FILL_W+7:0]    len_ext;

   sle_decode #(
      .LINE_DEPTH(LINE_DEPTH),
      .TAB_SPACES(TAB_SPACES)
   ) u_decode (
      .rx_byte         (req_rx_byte),
      .program_running (program_running_ff),
      .fill_count      (fill_count_ff),
      .dec             (dec)
   );

   // advance when a result is pending and the output register is free
   assign emit      = (seq_cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   // take a new item once the last result of the current one leaves the sequencer
   assign req_ready = (seq_cnt_ff == '0) || ((seq_cnt_ff == SLE_CNT_W'(1)) && emit);
   assign accept    = req_valid && req_ready;
   // line length is the count masked to eight bits
   assign len_ext   = {8'b0, seq_len_ff};

   always_comb begin
      program_running_in = csr_wr_en ? csr_wr_data : program_running_ff;

      fill_count_in = fill_count_ff;
      seq_op_in     = seq_op_ff;
      seq_cnt_in    = seq_cnt_ff;
      seq_char_in   = seq_char_ff;
      seq_len_in    = seq_len_ff;
      wr_ptr_in     = wr_ptr_ff;

      rsp_valid_in       = rsp_valid_ff;
      rsp_echo_valid_in  = rsp_echo_valid_ff;
      rsp_echo_byte_in   = rsp_echo_byte_ff;
      rsp_line_done_in   = rsp_line_done_ff;
      rsp_line_length_in = rsp_line_length_ff;
      rsp_last_result_in = rsp_last_result_ff;

      mem_we    = 1'b0;
      mem_wdata = CH_SPACE;

      // drop the output item once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_echo_valid_in  = 1'b1;
         rsp_echo_byte_in   = CH_SPACE;
         rsp_line_done_in   = 1'b0;
         rsp_line_length_in = '0;
         rsp_last_result_in = (seq_cnt_ff == SLE_CNT_W'(1));
         seq_cnt_in         = seq_cnt_ff - SLE_CNT_W'(1);
         case (seq_op_ff)
            OP_CHAR: begin
               rsp_echo_byte_in = seq_char_ff;
               mem_we           = 1'b1;
               mem_wdata        = seq_char_ff;
            end
            OP_TAB: begin
               mem_we = 1'b1;
            end
            OP_DEL: begin
               // backspace, space, backspace
               rsp_echo_byte_in = (seq_cnt_ff == SLE_CNT_W'(2)) ? CH_SPACE : CH_BS;
            end
            OP_EOL: begin
               rsp_echo_valid_in  = 1'b0;
               rsp_echo_byte_in   = '0;
               rsp_line_done_in   = 1'b1;
               rsp_line_length_in = len_ext[7:0];
            end
            default: begin
               rsp_echo_byte_in = '0;
            end
         endcase
         if (mem_we) begin
            wr_ptr_in = wr_ptr_ff + FILL_W'(1);
         end
      end

      // accept comes at the latest with the last emit of the current item;
      // load the new item over the sequencer state the emit left behind
      if (accept) begin
         seq_op_in   = dec.op;
         seq_cnt_in  = dec.count;
         seq_char_in = req_rx_byte;
         seq_len_in  = fill_count_ff;
         wr_ptr_in   = fill_count_ff;
         case (dec.op)
            OP_CHAR: fill_count_in = fill_count_ff + FILL_W'(1);
            OP_DEL:  fill_count_in = fill_count_ff - FILL_W'(1);
            OP_TAB:  fill_count_in = fill_count_ff + FILL_W'(TAB_SPACES);
            OP_EOL:  fill_count_in = '0;
            default: fill_count_in = fill_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_running_ff <= 1'b0;
         fill_count_ff      <= '0;
         seq_op_ff          <= OP_NONE;
         seq_cnt_ff         <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         program_running_ff <= program_running_in;
         fill_count_ff      <= fill_count_in;
         seq_op_ff          <= seq_op_in;
         seq_cnt_ff         <= seq_cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_char_ff        <= seq_char_in;
      seq_len_ff         <= seq_len_in;
      wr_ptr_ff          <= wr_ptr_in;
      rsp_echo_valid_ff  <= rsp_echo_valid_in;
      rsp_echo_byte_ff   <= rsp_echo_byte_in;
      rsp_line_done_ff   <= rsp_line_done_in;
      rsp_line_length_ff <= rsp_line_length_in;
      rsp_last_result_ff <= rsp_last_result_in;
   end

   // one entry written per stored character or tab space
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wr_ptr_ff[ADDR_W-1:0]] <= mem_wdata;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_valid  = rsp_echo_valid_ff;
   assign rsp_echo_byte   = rsp_echo_byte_ff;
   assign rsp_line_done   = rsp_line_done_ff;
   assign rsp_line_length = rsp_line_length_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // the fill count never passes the line depth
   `SLE_ASSERT(a_fill_bound, clock, reset, fill_count_ff <= FILL_W'(LINE_DEPTH))
   // a result that is not the last leaves more of its item in the sequencer
   `SLE_ASSERT(a_more_pending, clock, reset,
      (rsp_valid_ff && !rsp_last_result_ff) |-> (seq_cnt_ff != '0))
   // an item taken while a program runs starts no results
   `SLE_ASSERT(a_running_quiet, clock, reset,
      (accept && program_running_ff) |=> (seq_cnt_ff == '0))
   // each result is either an echo or a line end, never both
   `SLE_ASSERT(a_kind_exclusive, clock, reset,
      rsp_valid_ff |-> (rsp_echo_valid_ff != rsp_line_done_ff))

endmodule

// File: sim/sle_checker.sv
// Result checker for the shell line editor: tracks the line fill and mode,
// predicts the echo and line-done items per accepted byte and compares them.
// Depends on sle_pkg only.
`timescale 1ns / 100ps

module sle_checker
   import sle_pkg::*;
#(
   parameter int LINE_DEPTH = SLE_LINE_DEPTH,
   parameter int TAB_SPACES = SLE_TAB_SPACES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_echo_valid,
   input  logic [7:0] rsp_echo_byte,
   input  logic       rsp_line_done,
   input  logic [7:0] rsp_line_length,
   input  logic       rsp_last_result,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         fail_count,
   output int         echoes_due
);

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       line_done;
      logic [7:0] line_length;
      logic       last_result;
   } line_result_type;

   line_result_type pending_echoes[$];
   int              line_fill;
   logic            program_owns_tty;

   function automatic logic is_line_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9") || c == "_" || c == "-" || c == "." ||
             c == CH_SPACE;
   endfunction

   function automatic line_result_type echo_of(input logic [7:0] c);
      line_result_type r;
      r = '0;
      r.echo_valid = 1'b1;
      r.echo_byte  = c;
      return r;
   endfunction

   // Work out what one keystroke produces and advance the line state.
   task automatic apply_keystroke(input logic [7:0] c);
      line_result_type batch[$];
      line_result_type r;
      int              i;
      if (!program_owns_tty) begin
         if (is_line_char(c)) begin
            if (line_fill < LINE_DEPTH) begin
               line_fill++;
               batch.push_back(echo_of(c));
            end
         end else if (c == CH_BS || c == CH_DEL) begin
            if (line_fill != 0) begin
               line_fill--;
               batch.push_back(echo_of(CH_BS));
               batch.push_back(echo_of(CH_SPACE));
               batch.push_back(echo_of(CH_BS));
            end
         end else if (c == CH_TAB) begin
            if (line_fill + TAB_SPACES <= LINE_DEPTH) begin
               for (i = 0; i < TAB_SPACES; i++) begin
                  line_fill++;
                  batch.push_back(echo_of(CH_SPACE));
               end
            end
         end else if (c == CH_LF || c == CH_CR) begin
            r = '0;
            r.line_done   = 1'b1;
            r.line_length = line_fill[7:0];
            batch.push_back(r);
            line_fill = 0;
         end
      end
      if (batch.size() > 0) begin
         r = batch[batch.size() - 1];
         r.last_result = 1'b1;
         batch[batch.size() - 1] = r;
      end
      foreach (batch[k]) pending_echoes.push_back(batch[k]);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         line_fill = 0;
         program_owns_tty = 1'b0;
         pending_echoes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_echoes.size() == 0) begin
               $error("unexpected result item: echo %0b/0x%02h line %0b/%0d last %0b",
                      rsp_echo_valid, rsp_echo_byte, rsp_line_done, rsp_line_length,
                      rsp_last_result);
               fail_count++;
            end else begin
               want = pending_echoes.pop_front();
               check_field("echo_valid", want.echo_valid, rsp_echo_valid);
               check_field("echo_byte", want.echo_byte, rsp_echo_byte);
               check_field("line_done", want.line_done, rsp_line_done);
               check_field("line_length", want.line_length, rsp_line_length);
               check_field("last_result", want.last_result, rsp_last_result);
            end
         end
         if (req_valid && req_ready) apply_keystroke(req_rx_byte);
         // the mode written at this edge applies from the next item on
         if (csr_wr_en) program_owns_tty = csr_wr_data;
      end
      echoes_due <= pending_echoes.size();
   end

endmodule

// File: sim/tb_top.sv
// Testbench top for the shell line editor: clock, reset, keystroke stimulus,
// receiver stalls and the verdict. Depends on sle_pkg, sle_checker and the RTL.
`timescale 1ns / 100ps

module tb_top
   import sle_pkg::*;
();

   localparam int ITEM_GOAL       = 370;
   localparam int LINE_FILL_FIRST = SLE_LINE_DEPTH - 2;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_echo_valid;
   logic [7:0] rsp_echo_byte;
   logic       rsp_line_done;
   logic [7:0] rsp_line_length;
   logic       rsp_last_result;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   int fail_count;
   int echoes_due;

   // sender bookkeeping
   int items_sent = 0;
   int burst_left = 0;

   // receiver bookkeeping
   logic        long_hold_req   = 1'b0;
   logic        long_hold_taken = 1'b0;
   int          long_hold_left  = 0;
   int          rx_segment_left = 0;
   rx_mode_type rx_mode         = RX_OPEN;

   // Extremes of the byte, every edit key, delete on an empty line, bytes
   // just outside the accepted ranges, and a line ended with nothing in it.
   logic [7:0] opening_seq [24] = '{
      8'h00, 8'hFF, "!", CH_BS, CH_DEL, "A", "Z", "a", "z", "0", "9", "_",
      "-", ".", CH_SPACE, CH_TAB, "/", "{", "@", 8'h60, CH_BS, CH_DEL, CH_CR, CH_LF
   };

   shell_line_editor_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_last_result (rsp_last_result),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   sle_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_last_result (rsp_last_result),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .echoes_due      (echoes_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver: one long hold-off on request, otherwise stretches of random
   // length that are either fully open or stall lightly or heavily.
   always @(posedge clock) begin
      if (long_hold_left != 0) begin
         rsp_ready      <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else if (long_hold_req && !long_hold_taken) begin
         rsp_ready       <= 1'b0;
         long_hold_left  <= 90;
         long_hold_taken <= 1'b1;
      end else begin
         if (rx_segment_left == 0) begin
            rx_segment_left <= $urandom_range(4, 40);
            rx_mode         <= rx_mode_type'($urandom_range(0, 2));
         end else begin
            rx_segment_left <= rx_segment_left - 1;
         end
         case (rx_mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:  rsp_ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   // Offer one item and hold it until taken; close the burst with a gap
   // when its count runs out, otherwise keep valid high for the next item.
   task automatic offer_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Drop valid, wait for every predicted result, then let the pipe settle.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (echoes_due != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_program_running(input logic running);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= running;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] any_line_char();
      int k;
      k = $urandom_range(0, 65);
      if (k < 26) return 8'("A" + k);
      if (k < 52) return 8'("a" + k - 26);
      if (k < 62) return 8'("0" + k - 52);
      case (k)
         62:      return "_";
         63:      return "-";
         64:      return ".";
         default: return CH_SPACE;
      endcase
   endfunction

   // Type a line: mostly text, some tabs and rubouts, a little line noise,
   // closed by CR or LF.
   task automatic type_line(input int len);
      int pick;
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 82)      offer_byte(any_line_char());
         else if (pick < 90) offer_byte(CH_TAB);
         else if (pick < 96) offer_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
         else                offer_byte(8'($urandom_range(0, 255)));
      end
      offer_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   // Hand the terminal to a program, throw keystrokes at it, take it back.
   // These items are dropped by the block, so leave them out of the count.
   task automatic program_owned_phase();
      int saved;
      saved = items_sent;
      wait_quiet();
      set_program_running(1'b1);
      repeat (4) offer_byte(any_line_char());
      offer_byte(CH_TAB);
      offer_byte(CH_DEL);
      offer_byte(CH_CR);
      repeat (5) offer_byte(8'($urandom_range(0, 255)));
      wait_quiet();
      set_program_running(1'b0);
      items_sent = saved;
   endtask

   initial begin
      int  pick;
      bit  hold_done;
      bit  pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_seq[i]) offer_byte(opening_seq[i]);

      // Mode register at both values before the random part.
      program_owned_phase();

      // Fill the line to the brim: tab without room, characters dropped when
      // full, one rubout, a tab too wide, four rubouts, a tab that fits, full.
      repeat (LINE_FILL_FIRST) offer_byte(any_line_char());
      offer_byte(CH_TAB);
      repeat (2) offer_byte(any_line_char());
      repeat (3) offer_byte(any_line_char());
      offer_byte(CH_TAB);
      offer_byte(CH_DEL);
      offer_byte(CH_TAB);
      repeat (4) offer_byte(CH_BS);
      offer_byte(CH_TAB);
      offer_byte(any_line_char());
      offer_byte(CH_CR);

      while (items_sent < ITEM_GOAL) begin
         if (!hold_done && items_sent > ITEM_GOAL * 2 / 3) begin
            // Hold off the receiver while the sender keeps typing.
            hold_done = 1'b1;
            long_hold_req <= 1'b1;
            burst_left = 40;
         end
         if (!pause_done && items_sent > ITEM_GOAL * 5 / 6) begin
            // Stop typing until the block has answered everything.
            pause_done = 1'b1;
            program_owned_phase();
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            type_line($urandom_range(0, 14));
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 5)) offer_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) offer_byte(CH_DEL);
         end
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
